>>> rtl/core/mft_pkg.sv
`default_nettype none

package mft_pkg;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_ID_BASE      = 1'b0,
		REG_CALIB_FRAMES = 1'b1
	} cfg_reg_t;

	localparam int unsigned ID_W        = 11;
	localparam int unsigned PAYLOAD_W   = 56;
	localparam int unsigned ANGLE_W     = 16;
	localparam int unsigned FCNT_W      = 8;
	localparam int unsigned TOTAL_W     = 32;
	localparam int unsigned SLOT_OUT_W  = 3;
	// one turn is 8192 counts, so turns scale by a left shift of 13
	localparam int unsigned TURN_SHIFT  = 13;

	localparam logic [ID_W-1:0]        ID_BASE_RST      = 11'h201;
	localparam logic [FCNT_W-1:0]      CALIB_FRAMES_RST = 8'd51;
	localparam logic [FCNT_W-1:0]      FCNT_MAX         = 8'hFF;
	localparam logic signed [ANGLE_W:0] WRAP_POS        = 17'sd4096;
	localparam logic signed [ANGLE_W:0] WRAP_NEG        = -17'sd4096;
	localparam logic signed [ANGLE_W-1:0] TURN_MAX      = 16'sh7FFF;
	localparam logic signed [ANGLE_W-1:0] TURN_MIN      = 16'sh8000;

	// per-motor tracking state, one memory word per slot
	typedef struct packed {
		logic [ANGLE_W-1:0]        prev_angle;
		logic signed [ANGLE_W-1:0] turn_count;
		logic [ANGLE_W-1:0]        zero_offset;
		logic [FCNT_W-1:0]         frame_count;
	} entry_t;

	// result of one unwrap update
	typedef struct packed {
		entry_t                    nxt;
		logic signed [TOTAL_W-1:0] total;
		logic                      calib;
	} upd_t;

endpackage

`default_nettype wire

>>> rtl/core/motor_feedback_multiturn_tracker.sv
`default_nettype none

// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+-----------------------------------------
// input     | in        | in_valid/in_stall  | can_id, frame_payload
// output    | out       | out_valid/out_stall| motor_slot, rotor_angle, motor_speed,
//           |           |                    | drive_current, temperature, unwrapped_angle,
//           |           |                    | calibrating
// config    | in        | cfg_we             | cfg_idx, cfg_wdata
//
// One frame per cycle sustained while the output is not stalled; the state memory read is
// registered with the transaction, then the update is registered into the output register.
// Same-slot frames back to back are served by forwarding the just-written word.
// Reset clears the per-slot valid bits; an unwritten slot reads as all zero.
// A stall on the output holds the update stage, which then stalls the input.

module motor_feedback_multiturn_tracker
	import mft_pkg::*;
#(
	parameter int unsigned MOTOR_SLOTS = 7
) (
	input  var logic                      clk,
	input  var logic                      arst_n,

	input  var logic                      cfg_we,
	input  var cfg_reg_t                  cfg_idx,
	input  var logic [ID_W-1:0]           cfg_wdata,

	input  var logic                      in_valid,
	output logic                          in_stall,
	input  var logic [ID_W-1:0]           can_id,
	input  var logic [PAYLOAD_W-1:0]      frame_payload,

	output logic                          out_valid,
	input  var logic                      out_stall,
	output logic [SLOT_OUT_W-1:0]         motor_slot,
	output logic [ANGLE_W-1:0]            rotor_angle,
	output logic signed [15:0]            motor_speed,
	output logic signed [15:0]            drive_current,
	output logic [7:0]                    temperature,
	output logic signed [TOTAL_W-1:0]     unwrapped_angle,
	output logic                          calibrating
);

	localparam int unsigned SLOT_W = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;

	// configuration registers
	logic [ID_W-1:0]   id_base_q;
	logic [FCNT_W-1:0] calib_frames_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_base_q      <= ID_BASE_RST;
			calib_frames_q <= CALIB_FRAMES_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ID_BASE:      id_base_q      <= cfg_wdata;
				REG_CALIB_FRAMES: calib_frames_q <= cfg_wdata[FCNT_W-1:0];
				default:          ;
			endcase
		end
	end

	// slot decode on the incoming frame
	logic [ID_W-1:0]   slot_diff;
	logic              slot_hit;
	logic [SLOT_W-1:0] slot_in;
	logic              acc;
	logic              acc_hit;

	assign slot_diff = can_id - id_base_q;
	assign slot_hit  = slot_diff < ID_W'(MOTOR_SLOTS);
	assign slot_in   = slot_diff[SLOT_W-1:0];
	assign acc       = in_valid && !in_stall;
	assign acc_hit   = acc && slot_hit;

	// update stage control
	logic              valid_s1;
	logic              adv_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [ANGLE_W-1:0] angle_s1;
	logic [15:0]       speed_s1;
	logic [15:0]       current_s1;
	logic [7:0]        temp_s1;
	logic              out_valid_q;

	assign adv_s1   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;

	// state memory, valid bits and forwarding path
	entry_t                 mem [MOTOR_SLOTS];
	logic [MOTOR_SLOTS-1:0] vld_q;
	entry_t                 rd_q;
	logic                   rd_vld_q;
	entry_t                 wb_q;
	logic                   fwd_q;
	entry_t                 cur_s1;
	upd_t                   upd_s1;

	always_ff @(posedge clk) begin
		if (adv_s1) mem[slot_s1] <= upd_s1.nxt;
		if (acc_hit) rd_q <= mem[slot_in];
		if (adv_s1) wb_q <= upd_s1.nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
			fwd_q    <= 1'b0;
		end else begin
			if (adv_s1) vld_q[slot_s1] <= 1'b1;
			if (acc_hit) begin
				rd_vld_q <= vld_q[slot_in];
				fwd_q    <= adv_s1 && (slot_s1 == slot_in);
			end
		end
	end

	assign cur_s1 = fwd_q ? wb_q : (rd_vld_q ? rd_q : '0);

	// stage 1 payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= slot_hit;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_hit) begin
			slot_s1    <= slot_in;
			angle_s1   <= frame_payload[55:40];
			speed_s1   <= frame_payload[39:24];
			current_s1 <= frame_payload[23:8];
			temp_s1    <= frame_payload[7:0];
		end
	end

	mft_unwrap u_unwrap (
		.cur          (cur_s1),
		.angle        (angle_s1),
		.calib_frames (calib_frames_q),
		.upd          (upd_s1)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			motor_slot      <= SLOT_OUT_W'(slot_s1);
			rotor_angle     <= angle_s1;
			motor_speed     <= $signed(speed_s1);
			drive_current   <= $signed(current_s1);
			temperature     <= temp_s1;
			unwrapped_angle <= upd_s1.total;
			calibrating     <= upd_s1.calib;
		end
	end

	assign out_valid = out_valid_q;

	// checks
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty update stage");

	// a forwarded word always comes from a write that marked its slot
	a_fwd_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_q && valid_s1 |-> vld_q[slot_s1])
		else $error("forward flag without a preceding write");

	a_wr_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> vld_q[$past(slot_s1)])
		else $error("slot written but not marked valid");

	a_wr_counts_frame: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |-> upd_s1.nxt.frame_count != '0)
		else $error("frame count did not advance");

	a_calib_whole_turns: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && calibrating |-> unwrapped_angle[TURN_SHIFT-1:0] == '0)
		else $error("calibration total not a whole number of turns");

endmodule

`default_nettype wire

>>> rtl/core/mft_unwrap.sv
`default_nettype none

module mft_unwrap
	import mft_pkg::*;
(
	input  var entry_t             cur,
	input  var logic [ANGLE_W-1:0] angle,
	input  var logic [FCNT_W-1:0]  calib_frames,
	output upd_t                   upd
);

	logic signed [ANGLE_W:0]   delta;
	logic                      calib;
	logic signed [ANGLE_W-1:0] turn_nxt;
	logic signed [TOTAL_W-1:0] turn_scaled;

	assign calib = cur.frame_count < calib_frames;
	assign delta = $signed({1'b0, angle}) - $signed({1'b0, cur.prev_angle});

	// outside calibration the turn counter steps on a wrap, saturating at both ends
	always_comb begin
		turn_nxt = cur.turn_count;
		if (!calib) begin
			if (delta > WRAP_POS) begin
				if (cur.turn_count != TURN_MIN) turn_nxt = cur.turn_count - 16'sd1;
			end else if (delta < WRAP_NEG) begin
				if (cur.turn_count != TURN_MAX) turn_nxt = cur.turn_count + 16'sd1;
			end
		end
	end

	assign turn_scaled = {{(TOTAL_W-ANGLE_W-TURN_SHIFT){turn_nxt[ANGLE_W-1]}}, turn_nxt,
		{TURN_SHIFT{1'b0}}};

	always_comb begin
		upd.nxt.prev_angle   = angle;
		upd.nxt.turn_count   = turn_nxt;
		upd.nxt.zero_offset  = calib ? angle : cur.zero_offset;
		upd.nxt.frame_count  = (cur.frame_count == FCNT_MAX) ? FCNT_MAX
			: cur.frame_count + 8'd1;
		upd.calib            = calib;
		upd.total            = turn_scaled
			+ $signed({{(TOTAL_W-ANGLE_W){1'b0}}, angle})
			- $signed({{(TOTAL_W-ANGLE_W){1'b0}}, upd.nxt.zero_offset});
	end

endmodule

`default_nettype wire
